// File: rtl/nnup_pkg.sv
// ----------------------------------------------------------------------------
// nnup_pkg
// Shared types and constants for the nearest-neighbor tensor upscaler.
// ----------------------------------------------------------------------------
package nnup_pkg;

  // Field widths of the configuration registers
  localparam int ROW_CNT_W   = 11;
  localparam int COL_CNT_W   = 9;
  localparam int CHAN_CNT_W  = 6;
  localparam int SCALE_CNT_W = 5;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 2;

  // Width used for counter-versus-limit compares (all counters stay below 1024)
  localparam int CMP_W = 12;

  // Element width
  localparam int DATA_W = 8;

  // Item kind on the input side
  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_PULL = 1'b1
  } action_t;

  // Result status
  typedef enum logic [1:0] {
    ST_PUSH_TAKEN = 2'd0,
    ST_PUSH_BUSY  = 2'd1,
    ST_GIVEN      = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT     = 2'd0,
    CFG_COLUMN_COUNT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2,
    CFG_SCALE_FACTOR  = 2'd3
  } cfg_idx_t;

  // Decision for one item, from the sequencer to the datapath
  typedef struct packed {
    status_t status;
    logic    row_end;
    logic    frame_end;
    logic    store_wr;
    logic    store_rd;
  } step_t;

endpackage

// File: rtl/nearest_neighbor_tensor_upscaler_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_tensor_upscaler_unit
// Nearest-neighbor upscaler: stores one source row, then replays it scaled.
// ----------------------------------------------------------------------------
// Accepts one item per clock, push or pull, unless the output stalls, and
// returns exactly one result item per input item, via the line store read
// register and the output register. Throughput is set by the single-port
// line store, one write (push) or one read (pull) per cycle. The result is
// held in an output register so a new item is taken while the previous
// result waits. Pushes fill one source row (columns x channels); after the
// last element the unit emits, and pulls return each cell repeated
// scale_factor times across and each widened row scale_factor times down.
// A push while emitting is refused; a pull while loading reports empty.
module nearest_neighbor_tensor_upscaler_unit #(
  parameter int MAX_COLUMNS  = 256,
  parameter int MAX_CHANNELS = 32,
  parameter int MAX_SCALE    = 16,
  parameter int MAX_ROWS     = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input item stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] source_value
  input  logic                             in_tuser,   // [0] action
  // result item stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [7:0] result_value
  output logic [2:0]                       out_tuser,  // [1:0] status, [2] row_end
  output logic                             out_tlast,  // frame_end
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nnup_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nnup_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH  = MAX_COLUMNS * MAX_CHANNELS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [nnup_pkg::ROW_CNT_W-1:0]   row_count_r;
  logic [nnup_pkg::COL_CNT_W-1:0]   column_count_r;
  logic [nnup_pkg::CHAN_CNT_W-1:0]  channel_count_r;
  logic [nnup_pkg::SCALE_CNT_W-1:0] scale_factor_r;

  logic              in_accept;
  logic              a_adv;
  logic              a_valid_r, a_valid_nxt;
  nnup_pkg::step_t   a_step_r;
  nnup_pkg::step_t   step;
  logic [ADDR_W-1:0] store_addr;
  logic [nnup_pkg::DATA_W-1:0] line_store [DEPTH];
  logic [nnup_pkg::DATA_W-1:0] rd_r;

  logic              out_valid_r, out_valid_nxt;
  nnup_pkg::status_t out_status_r;
  logic [7:0]        out_value_r;
  logic              out_row_end_r;
  logic              out_frame_end_r;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r     <= nnup_pkg::ROW_CNT_W'(1);
      column_count_r  <= nnup_pkg::COL_CNT_W'(1);
      channel_count_r <= nnup_pkg::CHAN_CNT_W'(1);
      scale_factor_r  <= nnup_pkg::SCALE_CNT_W'(1);
    end else if (cfg_valid) begin
      case (nnup_pkg::cfg_idx_t'(cfg_index))
        nnup_pkg::CFG_ROW_COUNT:     row_count_r     <= cfg_data[nnup_pkg::ROW_CNT_W-1:0];
        nnup_pkg::CFG_COLUMN_COUNT:  column_count_r  <= cfg_data[nnup_pkg::COL_CNT_W-1:0];
        nnup_pkg::CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[nnup_pkg::CHAN_CNT_W-1:0];
        nnup_pkg::CFG_SCALE_FACTOR:  scale_factor_r  <= cfg_data[nnup_pkg::SCALE_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: stage A (store read) feeds the output register
  assign a_adv     = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || a_adv;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_accept) a_valid_nxt = 1'b1;
    else if (a_adv) a_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (a_adv) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  // Sequencer
  nnup_ctrl #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_SCALE    (MAX_SCALE),
    .MAX_ROWS     (MAX_ROWS),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (in_accept),
    .action        (nnup_pkg::action_t'(in_tuser)),
    .row_count     (row_count_r),
    .column_count  (column_count_r),
    .channel_count (channel_count_r),
    .scale_factor  (scale_factor_r),
    .step          (step),
    .store_addr    (store_addr)
  );

  // Line store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (step.store_wr) line_store[store_addr] <= in_tdata;
    if (step.store_rd) rd_r <= line_store[store_addr];
  end

  // Stage A: hold the item's decision next to the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) a_step_r <= step;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_status_r    <= a_step_r.status;
      out_value_r     <= a_step_r.store_rd ? rd_r : '0;
      out_row_end_r   <= a_step_r.row_end;
      out_frame_end_r <= a_step_r.frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_row_end_r, out_status_r};
  assign out_tlast  = out_frame_end_r;

`ifndef SYNTHESIS
  // Frame end only on the last element of an output row
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[2])
    else $error("frame end without row end");

  // Value is zero unless an element is given
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] != nnup_pkg::ST_GIVEN) |-> (out_tdata == '0))
    else $error("nonzero value on a result without an element");

  // Input stalls only when both stages are full and the output is not taken
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (a_valid_r && out_valid_r && !out_tready))
    else $error("input stalled with room in the pipeline");

  // Store is never written and read for the same item
  assert property (@(posedge clk) disable iff (!rst_n)
    !(step.store_wr && step.store_rd))
    else $error("store written and read at once");
`endif

endmodule

// File: rtl/nnup_ctrl.sv
// ----------------------------------------------------------------------------
// nnup_ctrl
// Load and emit sequencer: decides each item's status and flags, advances
// the load and replication counters and drives the line store address.
// ----------------------------------------------------------------------------
module nnup_ctrl #(
  parameter int MAX_COLUMNS  = 256,
  parameter int MAX_CHANNELS = 32,
  parameter int MAX_SCALE    = 16,
  parameter int MAX_ROWS     = 1024,
  parameter int ADDR_W       = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step_en,
  input  nnup_pkg::action_t                 action,
  input  logic [nnup_pkg::ROW_CNT_W-1:0]    row_count,
  input  logic [nnup_pkg::COL_CNT_W-1:0]    column_count,
  input  logic [nnup_pkg::CHAN_CNT_W-1:0]   channel_count,
  input  logic [nnup_pkg::SCALE_CNT_W-1:0]  scale_factor,
  output nnup_pkg::step_t                   step,
  output logic [ADDR_W-1:0]                 store_addr
);

  // Effective limits: the parameter, capped at 1024 rows, 256 columns, 32 channels, 16 scale
  localparam int ROW_LIM = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
  localparam int COL_LIM = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
  localparam int CH_LIM  = (MAX_CHANNELS < 32) ? MAX_CHANNELS : 32;
  localparam int SC_LIM  = (MAX_SCALE < 16) ? MAX_SCALE : 16;

  localparam int ROW_W = (ROW_LIM > 1) ? $clog2(ROW_LIM) : 1;
  localparam int COL_W = (COL_LIM > 1) ? $clog2(COL_LIM) : 1;
  localparam int CH_W  = (CH_LIM > 1) ? $clog2(CH_LIM) : 1;
  localparam int SC_W  = (SC_LIM > 1) ? $clog2(SC_LIM) : 1;

  localparam int CW = nnup_pkg::CMP_W;

  localparam logic [nnup_pkg::ROW_CNT_W-1:0]   ROW_LIM_V = nnup_pkg::ROW_CNT_W'(ROW_LIM);
  localparam logic [nnup_pkg::COL_CNT_W-1:0]   COL_LIM_V = nnup_pkg::COL_CNT_W'(COL_LIM);
  localparam logic [nnup_pkg::CHAN_CNT_W-1:0]  CH_LIM_V  = nnup_pkg::CHAN_CNT_W'(CH_LIM);
  localparam logic [nnup_pkg::SCALE_CNT_W-1:0] SC_LIM_V  = nnup_pkg::SCALE_CNT_W'(SC_LIM);

  logic [nnup_pkg::ROW_CNT_W-1:0]   rows_b;
  logic [nnup_pkg::COL_CNT_W-1:0]   cols_b;
  logic [nnup_pkg::CHAN_CNT_W-1:0]  chans_b;
  logic [nnup_pkg::SCALE_CNT_W-1:0] scale_b;

  logic             emitting_r, emitting_nxt;
  logic [COL_W-1:0] load_col_r, load_col_nxt;
  logic [CH_W-1:0]  load_ch_r, load_ch_nxt;
  logic [SC_W-1:0]  down_rep_r, down_rep_nxt;
  logic [COL_W-1:0] emit_col_r, emit_col_nxt;
  logic [SC_W-1:0]  across_rep_r, across_rep_nxt;
  logic [CH_W-1:0]  emit_ch_r, emit_ch_nxt;
  logic [ROW_W-1:0] src_row_r, src_row_nxt;

  logic ld_ch_last, ld_col_last;
  logic ch_last, ac_last, col_last, dn_last, row_last, rend;

  logic [ADDR_W-1:0] load_addr, emit_addr;

  // Clamp register values into 1..limit
  always_comb begin
    if (row_count == '0) rows_b = nnup_pkg::ROW_CNT_W'(1);
    else if (row_count > ROW_LIM_V) rows_b = ROW_LIM_V;
    else rows_b = row_count;

    if (column_count == '0) cols_b = nnup_pkg::COL_CNT_W'(1);
    else if (column_count > COL_LIM_V) cols_b = COL_LIM_V;
    else cols_b = column_count;

    if (channel_count == '0) chans_b = nnup_pkg::CHAN_CNT_W'(1);
    else if (channel_count > CH_LIM_V) chans_b = CH_LIM_V;
    else chans_b = channel_count;

    if (scale_factor == '0) scale_b = nnup_pkg::SCALE_CNT_W'(1);
    else if (scale_factor > SC_LIM_V) scale_b = SC_LIM_V;
    else scale_b = scale_factor;
  end

  // Last-value flags for every counter
  assign ld_ch_last  = (CW'(load_ch_r) + CW'(1)) >= CW'(chans_b);
  assign ld_col_last = (CW'(load_col_r) + CW'(1)) >= CW'(cols_b);
  assign ch_last     = (CW'(emit_ch_r) + CW'(1)) >= CW'(chans_b);
  assign ac_last     = (CW'(across_rep_r) + CW'(1)) >= CW'(scale_b);
  assign col_last    = (CW'(emit_col_r) + CW'(1)) >= CW'(cols_b);
  assign dn_last     = (CW'(down_rep_r) + CW'(1)) >= CW'(scale_b);
  assign row_last    = (CW'(src_row_r) + CW'(1)) >= CW'(rows_b);
  assign rend        = ch_last && ac_last && col_last;

  // Store address: column-major slots of MAX_CHANNELS elements
  assign load_addr  = ADDR_W'(load_col_r) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(load_ch_r);
  assign emit_addr  = ADDR_W'(emit_col_r) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(emit_ch_r);
  assign store_addr = emitting_r ? emit_addr : load_addr;

  // Decide the item and advance the counters
  always_comb begin
    emitting_nxt   = emitting_r;
    load_col_nxt   = load_col_r;
    load_ch_nxt    = load_ch_r;
    down_rep_nxt   = down_rep_r;
    emit_col_nxt   = emit_col_r;
    across_rep_nxt = across_rep_r;
    emit_ch_nxt    = emit_ch_r;
    src_row_nxt    = src_row_r;
    step           = '0;
    step.status    = nnup_pkg::ST_EMPTY;

    if (step_en) begin
      if (action == nnup_pkg::ACT_PUSH) begin
        if (emitting_r) begin
          step.status = nnup_pkg::ST_PUSH_BUSY;
        end else begin
          step.status   = nnup_pkg::ST_PUSH_TAKEN;
          step.store_wr = 1'b1;
          if (ld_ch_last) begin
            load_ch_nxt = '0;
            if (ld_col_last) begin
              load_col_nxt   = '0;
              emitting_nxt   = 1'b1;
              down_rep_nxt   = '0;
              emit_col_nxt   = '0;
              across_rep_nxt = '0;
              emit_ch_nxt    = '0;
            end else begin
              load_col_nxt = load_col_r + COL_W'(1);
            end
          end else begin
            load_ch_nxt = load_ch_r + CH_W'(1);
          end
        end
      end else if (emitting_r) begin
        step.status    = nnup_pkg::ST_GIVEN;
        step.store_rd  = 1'b1;
        step.row_end   = rend;
        step.frame_end = rend && dn_last && row_last;
        // Channel fastest, then across repeat, column, down repeat
        if (!ch_last) begin
          emit_ch_nxt = emit_ch_r + CH_W'(1);
        end else begin
          emit_ch_nxt = '0;
          if (!ac_last) begin
            across_rep_nxt = across_rep_r + SC_W'(1);
          end else begin
            across_rep_nxt = '0;
            if (!col_last) begin
              emit_col_nxt = emit_col_r + COL_W'(1);
            end else begin
              emit_col_nxt = '0;
              if (!dn_last) begin
                down_rep_nxt = down_rep_r + SC_W'(1);
              end else begin
                down_rep_nxt = '0;
                emitting_nxt = 1'b0;
                src_row_nxt  = row_last ? '0 : src_row_r + ROW_W'(1);
              end
            end
          end
        end
      end
    end
  end

  // Hold counter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emitting_r   <= 1'b0;
      load_col_r   <= '0;
      load_ch_r    <= '0;
      down_rep_r   <= '0;
      emit_col_r   <= '0;
      across_rep_r <= '0;
      emit_ch_r    <= '0;
      src_row_r    <= '0;
    end else begin
      emitting_r   <= emitting_nxt;
      load_col_r   <= load_col_nxt;
      load_ch_r    <= load_ch_nxt;
      down_rep_r   <= down_rep_nxt;
      emit_col_r   <= emit_col_nxt;
      across_rep_r <= across_rep_nxt;
      emit_ch_r    <= emit_ch_nxt;
      src_row_r    <= src_row_nxt;
    end
  end

endmodule

// File: dv/tb_nearest_neighbor_tensor_upscaler_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_tensor_upscaler_unit
// Self-checking bench for the nearest-neighbor upscaler. A directed table
// covers reset behavior, busy and empty answers and a mid-row resize. Fixed
// phases then visit the register extremes. Random phases finish the run with
// mostly well-formed load/replay rows plus stray items. Every result item is
// checked against its typed result or the model of the store and counters.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_tensor_upscaler_unit;

  localparam int CELL_STRIDE  = 32;    // store entries per source column
  localparam int RANDOM_ITEMS = 130;
  localparam int QUIET_AFTER  = 90;
  localparam int STUCK_LIMIT  = 1000;
  localparam int REPORT_MAX   = 10;

  // One result item as the block reports it
  typedef struct packed {
    nnup_pkg::status_t status;
    logic [7:0]        value;
    logic              row_end;
    logic              frame_end;
  } upscale_result_t;

  // One line of the directed table: a register write or an input item
  typedef struct {
    bit                 is_reg;
    nnup_pkg::cfg_idx_t reg_idx;
    int unsigned        reg_val;
    nnup_pkg::action_t  act;
    logic [7:0]         val;
    bit                 typed;
    upscale_result_t    want;
  } directed_step_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [7:0]                      in_tdata;    // [7:0] source_value
  logic                            in_tuser;    // [0] action
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [7:0]                      out_tdata;   // [7:0] result_value
  logic [2:0]                      out_tuser;   // [1:0] status, [2] row_end
  logic                            out_tlast;   // frame_end
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [nnup_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [nnup_pkg::CFG_DATA_W-1:0] cfg_data;

  // Model state: line store, load and replay counters, register copies
  logic [7:0]  row_buf [CELL_STRIDE*256];
  int unsigned load_col, load_ch;
  bit          emitting;
  int unsigned down_rep, emit_col, across_rep, emit_ch, src_row;
  int unsigned reg_rows, reg_cols, reg_chans, reg_scale;

  upscale_result_t upscaled_q[$];
  directed_step_t  directed[$];
  int unsigned     bad_results = 0;
  int unsigned     stuck_cycles = 0;
  int unsigned     rand_items = 0;
  int unsigned     rx_stall_left = 0;
  bit              idle_enable = 1'b1;
  bit              quiet = 1'b0;

  nearest_neighbor_tensor_upscaler_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Zero and out-of-range register values act as the nearest bound
  function automatic int unsigned limit_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit at_row_start();
    return !emitting && load_col == 0 && load_ch == 0;
  endfunction

  // Advance the model by one accepted item and return its result
  function automatic upscale_result_t upscale_step(nnup_pkg::action_t act, logic [7:0] v);
    int unsigned     rows, cols, chans, scale;
    bit              ch_last, ac_last, col_last, dn_last, row_last;
    upscale_result_t r;
    rows  = limit_to(reg_rows, 1024);
    cols  = limit_to(reg_cols, 256);
    chans = limit_to(reg_chans, 32);
    scale = limit_to(reg_scale, 16);
    r.status    = nnup_pkg::ST_PUSH_TAKEN;
    r.value     = '0;
    r.row_end   = 1'b0;
    r.frame_end = 1'b0;

    if (act == nnup_pkg::ACT_PUSH) begin
      if (emitting) begin
        r.status = nnup_pkg::ST_PUSH_BUSY;
        return r;
      end
      row_buf[load_col*CELL_STRIDE + load_ch] = v;
      if (load_ch + 1 >= chans) begin
        load_ch = 0;
        if (load_col + 1 >= cols) begin
          load_col   = 0;
          emitting   = 1'b1;
          down_rep   = 0;
          emit_col   = 0;
          across_rep = 0;
          emit_ch    = 0;
        end else begin
          load_col++;
        end
      end else begin
        load_ch++;
      end
      return r;
    end

    if (!emitting) begin
      r.status = nnup_pkg::ST_EMPTY;
      return r;
    end

    ch_last  = emit_ch + 1 >= chans;
    ac_last  = across_rep + 1 >= scale;
    col_last = emit_col + 1 >= cols;
    dn_last  = down_rep + 1 >= scale;
    row_last = src_row + 1 >= rows;
    r.status    = nnup_pkg::ST_GIVEN;
    r.value     = row_buf[emit_col*CELL_STRIDE + emit_ch];
    r.row_end   = ch_last && ac_last && col_last;
    r.frame_end = r.row_end && dn_last && row_last;

    // Step the innermost counter that has not reached its limit
    if (!ch_last) begin
      emit_ch++;
      return r;
    end
    emit_ch = 0;
    if (!ac_last) begin
      across_rep++;
      return r;
    end
    across_rep = 0;
    if (!col_last) begin
      emit_col++;
      return r;
    end
    emit_col = 0;
    if (!dn_last) begin
      down_rep++;
      return r;
    end
    down_rep = 0;
    emitting = 1'b0;
    src_row  = row_last ? 0 : src_row + 1;
    return r;
  endfunction

  function automatic logic [7:0] pick_value();
    if ($urandom_range(0, 7) != 0) return 8'($urandom);
    case ($urandom_range(0, 3))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  // Hold until every outstanding result item has come back
  task automatic wait_idle();
    while (upscaled_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(nnup_pkg::cfg_idx_t idx, int unsigned val);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val[nnup_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      nnup_pkg::CFG_ROW_COUNT:     reg_rows  = val & 32'h7FF;
      nnup_pkg::CFG_COLUMN_COUNT:  reg_cols  = val & 32'h1FF;
      nnup_pkg::CFG_CHANNEL_COUNT: reg_chans = val & 32'h3F;
      nnup_pkg::CFG_SCALE_FACTOR:  reg_scale = val & 32'h1F;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drive one item, wait for the handshake, queue its expected result
  task automatic send_item(nnup_pkg::action_t act, logic [7:0] v, bit typed,
                           upscale_result_t want);
    upscale_result_t pred;
    if (idle_enable && !quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = v;
    do @(posedge clk); while (!in_tready);
    pred = upscale_step(act, v);
    upscaled_q.insert(upscaled_q.size(), typed ? want : pred);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Mostly well-formed traffic: fill while loading, drain while emitting
  task automatic run_items(int unsigned n);
    nnup_pkg::action_t act;
    repeat (n) begin
      if (emitting)
        act = ($urandom_range(0, 9) != 0) ? nnup_pkg::ACT_PULL : nnup_pkg::ACT_PUSH;
      else
        act = ($urandom_range(0, 9) != 0) ? nnup_pkg::ACT_PUSH : nnup_pkg::ACT_PULL;
      send_item(act, pick_value(), 1'b0, '0);
    end
  endtask

  // Complete the current row so that any new size is safe to load
  task automatic finish_row();
    while (!at_row_start())
      send_item(emitting ? nnup_pkg::ACT_PULL : nnup_pkg::ACT_PUSH, pick_value(),
                1'b0, '0);
  endtask

  task automatic fixed_phase(int unsigned rows, int unsigned cols, int unsigned chans,
                             int unsigned scale, int unsigned n);
    finish_row();
    write_reg(nnup_pkg::CFG_ROW_COUNT, rows);
    write_reg(nnup_pkg::CFG_COLUMN_COUNT, cols);
    write_reg(nnup_pkg::CFG_CHANNEL_COUNT, chans);
    write_reg(nnup_pkg::CFG_SCALE_FACTOR, scale);
    run_items(n);
  endtask

  // New random sizes; away from a row start only shrink columns and channels,
  // so no never-written store entry is ever replayed
  task automatic retune_random();
    int unsigned cur_cols, cur_chans;
    bit          fresh;
    fresh = at_row_start();
    if (!fresh && $urandom_range(0, 2) == 0) begin
      finish_row();
      fresh = 1'b1;
    end
    cur_cols  = fresh ? 6 : limit_to(reg_cols, 256);
    cur_chans = fresh ? 4 : limit_to(reg_chans, 32);
    if (cur_cols > 6) cur_cols = 6;
    if (cur_chans > 4) cur_chans = 4;
    if ($urandom_range(0, 3) != 0)
      write_reg(nnup_pkg::CFG_ROW_COUNT, $urandom_range(0, 5));
    if ($urandom_range(0, 3) != 0)
      write_reg(nnup_pkg::CFG_COLUMN_COUNT, $urandom_range(0, cur_cols));
    if ($urandom_range(0, 3) != 0)
      write_reg(nnup_pkg::CFG_CHANNEL_COUNT, $urandom_range(0, cur_chans));
    if ($urandom_range(0, 3) != 0)
      write_reg(nnup_pkg::CFG_SCALE_FACTOR, $urandom_range(0, 4));
  endtask

  // Table line for a register write
  task automatic add_reg(nnup_pkg::cfg_idx_t idx, int unsigned rv);
    directed_step_t s;
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = rv;
    s.act     = nnup_pkg::ACT_PUSH;
    s.val     = '0;
    s.typed   = 1'b0;
    s.want    = '0;
    directed.insert(directed.size(), s);
  endtask

  // Table line for an input item, with its typed result where given
  task automatic add_item(nnup_pkg::action_t act, logic [7:0] v, bit typed,
                          nnup_pkg::status_t st, logic [7:0] ev, bit re, bit fe);
    directed_step_t s;
    s.is_reg         = 1'b0;
    s.reg_idx        = nnup_pkg::CFG_ROW_COUNT;
    s.reg_val        = 0;
    s.act            = act;
    s.val            = v;
    s.typed          = typed;
    s.want.status    = st;
    s.want.value     = ev;
    s.want.row_end   = re;
    s.want.frame_end = fe;
    directed.insert(directed.size(), s);
  endtask

  // Receiver: random stall bursts, none once the run goes quiet
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      out_tready = 1'b0;
      rx_stall_left--;
    end else if (idle_enable && !quiet && $urandom_range(0, 5) == 0) begin
      out_tready = 1'b0;
      rx_stall_left = $urandom_range(1, 12) - 1;
    end else begin
      out_tready = 1'b1;
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin
    upscale_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status    = nnup_pkg::status_t'(out_tuser[1:0]);
      got.value     = out_tdata;
      got.row_end   = out_tuser[2];
      got.frame_end = out_tlast;
      if (upscaled_q.size() == 0) begin
        bad_results++;
        if (bad_results <= REPORT_MAX)
          $display("%0t: result item with nothing pending: status %0d value %0d",
                   $time, got.status, $signed(got.value));
      end else begin
        want = upscaled_q.pop_front();
        if (got !== want) begin
          bad_results++;
          if (bad_results <= REPORT_MAX)
            $display({"%0t: result error: status %0d/%0d value %0d/%0d ",
                      "row_end %0b/%0b frame_end %0b/%0b (expected/actual)"},
                     $time, want.status, got.status, $signed(want.value),
                     $signed(got.value), want.row_end, got.row_end,
                     want.frame_end, got.frame_end);
        end
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    load_col = 0; load_ch = 0; emitting = 1'b0;
    down_rep = 0; emit_col = 0; across_rep = 0; emit_ch = 0; src_row = 0;
    reg_rows = 1; reg_cols = 1; reg_chans = 1; reg_scale = 1;

    // Directed table: reset sizes, busy and empty answers, then a resize
    // at a row start and a shrink in the middle of loading a row
    //       act                 data   typ status                   val    re fe
    add_item(nnup_pkg::ACT_PULL, 8'h00, 1, nnup_pkg::ST_EMPTY,      8'h00, 0, 0);
    add_item(nnup_pkg::ACT_PUSH, 8'h7F, 1, nnup_pkg::ST_PUSH_TAKEN, 8'h00, 0, 0);
    add_item(nnup_pkg::ACT_PUSH, 8'h80, 1, nnup_pkg::ST_PUSH_BUSY,  8'h00, 0, 0);
    add_item(nnup_pkg::ACT_PULL, 8'hFF, 1, nnup_pkg::ST_GIVEN,      8'h7F, 1, 1);
    add_item(nnup_pkg::ACT_PULL, 8'h00, 1, nnup_pkg::ST_EMPTY,      8'h00, 0, 0);
    add_reg(nnup_pkg::CFG_ROW_COUNT,     2047);
    add_reg(nnup_pkg::CFG_COLUMN_COUNT,  2);
    add_reg(nnup_pkg::CFG_CHANNEL_COUNT, 0);
    add_reg(nnup_pkg::CFG_SCALE_FACTOR,  2);
    add_item(nnup_pkg::ACT_PUSH, 8'h80, 1, nnup_pkg::ST_PUSH_TAKEN, 8'h00, 0, 0);
    add_item(nnup_pkg::ACT_PUSH, 8'h01, 1, nnup_pkg::ST_PUSH_TAKEN, 8'h00, 0, 0);
    add_item(nnup_pkg::ACT_PUSH, 8'hFF, 1, nnup_pkg::ST_PUSH_BUSY,  8'h00, 0, 0);
    repeat (8)
      add_item(nnup_pkg::ACT_PULL, 8'h55, 0, nnup_pkg::ST_EMPTY,    8'h00, 0, 0);
    add_item(nnup_pkg::ACT_PULL, 8'h00, 1, nnup_pkg::ST_EMPTY,      8'h00, 0, 0);
    add_reg(nnup_pkg::CFG_COLUMN_COUNT,  3);
    add_reg(nnup_pkg::CFG_CHANNEL_COUNT, 2);
    add_item(nnup_pkg::ACT_PUSH, 8'h55, 0, nnup_pkg::ST_EMPTY,      8'h00, 0, 0);
    add_item(nnup_pkg::ACT_PUSH, 8'hAA, 0, nnup_pkg::ST_EMPTY,      8'h00, 0, 0);
    add_item(nnup_pkg::ACT_PUSH, 8'h00, 0, nnup_pkg::ST_EMPTY,      8'h00, 0, 0);
    add_reg(nnup_pkg::CFG_COLUMN_COUNT,  2);
    add_reg(nnup_pkg::CFG_CHANNEL_COUNT, 1);
    add_item(nnup_pkg::ACT_PUSH, 8'h7F, 0, nnup_pkg::ST_EMPTY,      8'h00, 0, 0);

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_reg)
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      else
        send_item(directed[i].act, directed[i].val, directed[i].typed, directed[i].want);
    end

    // Register extremes, one large dimension at a time
    fixed_phase(3, 4, 2, 2, 40);
    fixed_phase(2, 1, 63, 1, 64);
    fixed_phase(2047, 1, 1, 1, 30);
    fixed_phase(0, 0, 0, 0, 20);
    fixed_phase(1, 1, 1, 31, 257);

    // Random phases of small sizes; the tail runs without idling
    while (rand_items < RANDOM_ITEMS) begin
      int unsigned n;
      n = $urandom_range(20, 70);
      idle_enable = $urandom_range(0, 3) != 0;
      if (rand_items >= QUIET_AFTER) quiet = 1'b1;
      retune_random();
      run_items(n);
      rand_items += n;
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (bad_results == 0 && upscaled_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
rtl/nnup_pkg.sv
rtl/nnup_ctrl.sv
rtl/nearest_neighbor_tensor_upscaler_unit.sv
dv/tb_nearest_neighbor_tensor_upscaler_unit.sv
